>>> rtl/core/sgnl_pkg.sv
// Shared widths, codes and types of the sphere grid neighbour lister.
package sgnl_pkg;

   localparam int FUNC_W      = 2;
   localparam int ID_W        = 20;
   localparam int VALUE_W     = 21;
   localparam int START_W     = 21;
   localparam int COUNT_W     = 11;
   localparam int CAND_W      = 22;
   localparam int QUO_W       = 22;
   localparam int NUM_W       = 43;
   localparam int CNT_W       = 24;
   localparam int MASK_WORD_W = 16;
   localparam int MASK_SEL_W  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam int DEF_MAX_ROWS  = 1024;
   localparam int DEF_MAX_NODES = 1048576;
   localparam int DEF_MAX_OUT   = 64;

   localparam logic [COUNT_W-1:0] ROW_COUNT_RESET = 11'd2;
   localparam logic [COUNT_W-1:0] ROW_COUNT_MIN   = 11'd2;

   localparam logic [FUNC_W-1:0] FUNC_ROW_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WATER_LOAD = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 2'd2;

   typedef enum logic [1:0] {
      OP_ROW_LOAD   = 2'd0,
      OP_WATER_LOAD = 2'd1,
      OP_QUERY      = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [ID_W-1:0]    index;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

>>> rtl/core/sgnl_chan_if.sv
// Handshake channel interfaces for the request and result streams.
interface sgnl_req_if;
   logic                         valid;
   logic                         ready;
   logic [sgnl_pkg::FUNC_W-1:0]  func;
   logic [sgnl_pkg::ID_W-1:0]    index;
   logic [sgnl_pkg::VALUE_W-1:0] value;
   modport source (output valid, output func, output index, output value, input ready);
   modport sink (input valid, input func, input index, input value, output ready);
endinterface

interface sgnl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sgnl_pkg::ID_W-1:0] neighbour_id;
   logic                      found;
   logic                      last;
   modport source (output valid, output neighbour_id, output found, output last, input ready);
   modport sink (input valid, input neighbour_id, input found, input last, output ready);
endinterface

>>> rtl/core/sgnl_front.sv
// Front end: accepts request items, decodes them and drops those that do nothing.
module sgnl_front #(
   parameter int MAX_ROWS  = sgnl_pkg::DEF_MAX_ROWS,
   parameter int MAX_NODES = sgnl_pkg::DEF_MAX_NODES
) (
   input  logic                 clock,
   input  logic                 reset,
   sgnl_req_if.sink             req_if,
   input  sgnl_pkg::status_type status,
   output logic                 cmd_valid,
   output sgnl_pkg::cmd_type    cmd,
   input  logic                 cmd_ready
);

   logic              hold_valid_ff, hold_valid_in;
   sgnl_pkg::cmd_type hold_ff, hold_in;
   logic              accept;
   logic              keep;

   assign req_if.ready = !status.clearing && (!hold_valid_ff || cmd_ready);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      hold_in.index = req_if.index;
      hold_in.value = req_if.value;
      hold_in.op    = sgnl_pkg::OP_QUERY;
      keep          = 1'b0;
      unique case (req_if.func)
         sgnl_pkg::FUNC_ROW_LOAD: begin
            hold_in.op = sgnl_pkg::OP_ROW_LOAD;
            keep       = 32'(req_if.index) <= 32'(MAX_ROWS);
         end
         sgnl_pkg::FUNC_WATER_LOAD: begin
            hold_in.op = sgnl_pkg::OP_WATER_LOAD;
            keep       = 32'(req_if.index) < 32'(MAX_NODES);
         end
         sgnl_pkg::FUNC_QUERY: begin
            hold_in.op = sgnl_pkg::OP_QUERY;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = keep;
      end else if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

   assign cmd_valid = hold_valid_ff;
   assign cmd       = hold_ff;

endmodule

>>> rtl/core/sgnl_queue.sv
// Short command queue between the front end and the engine.
module sgnl_queue #(
   parameter int DEPTH = sgnl_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sgnl_pkg::cmd_type in_cmd,
   output logic              in_ready,
   output logic              out_valid,
   output sgnl_pkg::cmd_type out_cmd,
   input  logic              out_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sgnl_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

>>> rtl/core/sgnl_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module sgnl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sgnl_pkg::NUM_W-1:0]   num,
   input  logic [sgnl_pkg::START_W-1:0] den,
   output logic                          busy,
   output logic [sgnl_pkg::QUO_W-1:0]   quo
);

   localparam int NW = sgnl_pkg::NUM_W;
   localparam int DW = sgnl_pkg::START_W;
   localparam int SW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic [SW-1:0] step_ff, step_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic          fits;

   // The dividend shifts out at the top while quotient bits shift in below.
   assign trial = {rem_ff, num_ff[NW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in  = {num_ff[NW-2:0], fits};
         rem_in  = fits ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = sgnl_pkg::QUO_W'(num_ff);

endmodule

>>> rtl/core/sgnl_back.sv
// Engine: holds the row start table and water mask, runs loads and neighbour queries.
module sgnl_back #(
   parameter int MAX_ROWS  = sgnl_pkg::DEF_MAX_ROWS,
   parameter int MAX_NODES = sgnl_pkg::DEF_MAX_NODES,
   parameter int MAX_OUT   = sgnl_pkg::DEF_MAX_OUT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  sgnl_pkg::cmd_type                   cmd,
   output logic                                cmd_ready,
   input  logic [$clog2(MAX_ROWS + 1)-1:0]     rows,
   output sgnl_pkg::status_type                status,
   sgnl_rsp_if.source                          rsp_if
);

   localparam int TBL_AW     = $clog2(MAX_ROWS + 1);
   localparam int TBL_DEPTH  = MAX_ROWS + 1;
   localparam int MASK_DEPTH = (MAX_NODES + sgnl_pkg::MASK_WORD_W - 1) / sgnl_pkg::MASK_WORD_W;
   localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
   localparam int HIT_W      = $clog2(MAX_OUT + 1);
   localparam int SW         = sgnl_pkg::START_W;
   localparam int IW         = sgnl_pkg::ID_W;
   localparam int CW         = sgnl_pkg::CAND_W;
   localparam int QW         = sgnl_pkg::QUO_W;
   localparam int NW         = sgnl_pkg::NUM_W;
   localparam int KW         = sgnl_pkg::CNT_W;
   localparam int MW         = sgnl_pkg::MASK_WORD_W;
   localparam int XW         = sgnl_pkg::MASK_SEL_W;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_WATER  = 14'b00000000000100,
      S_SCAN1  = 14'b00000000001000,
      S_SCAN2  = 14'b00000000010000,
      S_WALK   = 14'b00000000100000,
      S_JUDGE  = 14'b00000001000000,
      S_SIDE   = 14'b00000010000000,
      S_ADJ1   = 14'b00000100000000,
      S_ADJ2   = 14'b00001000000000,
      S_MUL    = 14'b00010000000000,
      S_DIVGO  = 14'b00100000000000,
      S_DIVW   = 14'b01000000000000,
      S_FINISH = 14'b10000000000000
   } state_type;

   typedef enum logic [3:0] {
      PH_LEFT  = 4'b0001,
      PH_RIGHT = 4'b0010,
      PH_UP    = 4'b0100,
      PH_DOWN  = 4'b1000
   } phase_type;

   // Memories.
   logic [SW-1:0]     tbl_mem [TBL_DEPTH];
   logic              tbl_we;
   logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
   logic [SW-1:0]     tbl_wdata;
   logic [SW-1:0]     tbl_q_ff;
   logic [MW-1:0]      mask_mem [MASK_DEPTH];
   logic               mask_we;
   logic [MASK_AW-1:0] mask_waddr, mask_raddr;
   logic [MW-1:0]      mask_wdata;
   logic [MW-1:0]      mask_q_ff;

   // Control state.
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [MASK_AW-1:0] clr_addr_ff, clr_addr_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [HIT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic               adj_hi_ff, adj_hi_in;
   logic [KW-1:0]      left_ff, left_in;
   logic               out_valid_ff, out_valid_in;

   // Datapath registers.
   sgnl_pkg::cmd_type cmd_ff, cmd_in;
   logic [TBL_AW-1:0] row_ff, row_in;
   logic [TBL_AW-1:0] o_ff, o_in;
   logic [SW-1:0]     a_ff, a_in;
   logic [SW-1:0]     wt_ff, wt_in;
   logic [SW-1:0]     n_ff, n_in;
   logic [SW-1:0]     so_ff, so_in;
   logic [SW-1:0]     wo_ff, wo_in;
   logic [NW-1:0]     prod_ff, prod_in;
   logic [SW-1:0]     addend_ff, addend_in;
   logic [QW-1:0]     lo_q_ff, lo_q_in;
   logic [SW-1:0]     base_ff, base_in;
   logic [SW-1:0]     wid_ff, wid_in;
   logic [SW-1:0]     col_ff, col_in;
   logic              skip_ff, skip_in;
   logic [IW-1:0]     cand_ff, cand_in;
   logic [IW-1:0]     pend_ff, pend_in;
   logic [IW-1:0]     out_id_ff, out_id_in;
   logic              out_found_ff, out_found_in;
   logic              out_last_ff, out_last_in;

   // Combinational helpers.
   logic          slot_free;
   logic          full;
   logic [SW-1:0] idx_ext;
   logic [SW-1:0] scan_wt, scan_n;
   logic [SW-1:0] col_next;
   logic [CW-1:0] cand_id;
   logic          cand_ok;
   logic [QW-1:0] mul_a;
   logic [NW-1:0] mul_full;
   logic          div_start;
   logic [NW-1:0] div_num;
   logic          div_busy;
   logic [QW-1:0] div_quo;
   logic          polar;

   sgnl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (wt_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   assign slot_free = !out_valid_ff || rsp_if.ready;
   assign full      = hit_cnt_ff == HIT_W'(MAX_OUT);
   assign idx_ext   = {1'b0, cmd_ff.index};
   assign scan_wt   = tbl_q_ff - a_ff;
   assign scan_n    = idx_ext - a_ff;
   assign col_next  = ({1'b0, col_ff} + 22'd1 == {1'b0, wid_ff}) ? '0 : col_ff + SW'(1);
   assign cand_id   = CW'(base_ff) + CW'(col_ff);
   // Ids past the node range, or past what a water load can reach, are land.
   assign cand_ok   = (32'(cand_id) < 32'(MAX_NODES)) && (cand_id[CW-1:IW] == '0);
   assign mul_a     = adj_hi_ff ? QW'({1'b0, n_ff} + 22'd1)
                    : (n_ff == '0) ? QW'(1) : QW'(n_ff - SW'(1));
   assign mul_full  = mul_a * wo_ff;
   assign div_num   = prod_ff + NW'(addend_ff);
   assign polar     = ((phase_ff == PH_UP) && (row_ff == rows - TBL_AW'(1)))
                   || ((phase_ff == PH_DOWN) && (row_ff == '0));
   assign status.clearing = state_ff == S_CLEAR;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      clr_addr_in   = clr_addr_ff;
      pend_valid_in = pend_valid_ff;
      hit_cnt_in    = hit_cnt_ff;
      adj_hi_in     = adj_hi_ff;
      left_in       = left_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      o_in          = o_ff;
      a_in          = a_ff;
      wt_in         = wt_ff;
      n_in          = n_ff;
      so_in         = so_ff;
      wo_in         = wo_ff;
      prod_in       = prod_ff;
      addend_in     = addend_ff;
      lo_q_in       = lo_q_ff;
      base_in       = base_ff;
      wid_in        = wid_ff;
      col_in        = col_ff;
      skip_in       = skip_ff;
      cand_in       = cand_ff;
      pend_in       = pend_ff;
      out_id_in     = out_id_ff;
      out_found_in  = out_found_ff;
      out_last_in   = out_last_ff;
      cmd_ready     = 1'b0;
      tbl_we        = 1'b0;
      tbl_waddr     = TBL_AW'(cmd.index);
      tbl_wdata     = cmd.value;
      tbl_raddr     = o_ff;
      mask_we       = 1'b0;
      mask_waddr    = MASK_AW'(cmd_ff.index >> XW);
      mask_wdata    = mask_q_ff;
      // Holding the read address keeps the probed word steady while a result waits.
      mask_raddr    = MASK_AW'(cand_ff >> XW);
      div_start     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mask_we     = 1'b1;
            mask_waddr  = clr_addr_ff;
            mask_wdata  = '0;
            clr_addr_in = clr_addr_ff + MASK_AW'(1);
            if (clr_addr_ff == MASK_AW'(MASK_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               unique case (cmd.op)
                  sgnl_pkg::OP_ROW_LOAD: begin
                     tbl_we = 1'b1;
                  end
                  sgnl_pkg::OP_WATER_LOAD: begin
                     mask_raddr = MASK_AW'(cmd.index >> XW);
                     state_in   = S_WATER;
                  end
                  sgnl_pkg::OP_QUERY: begin
                     tbl_raddr     = '0;
                     row_in        = '0;
                     pend_valid_in = 1'b0;
                     hit_cnt_in    = '0;
                     state_in      = S_SCAN1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WATER: begin
            mask_we = 1'b1;
            mask_wdata[cmd_ff.index[XW-1:0]] = cmd_ff.value[0];
            state_in = S_IDLE;
         end
         S_SCAN1: begin
            a_in      = tbl_q_ff;
            tbl_raddr = row_ff + TBL_AW'(1);
            state_in  = S_SCAN2;
         end
         S_SCAN2: begin
            // One row per cycle: the start of row r+1 arrives while row r is checked.
            if ((a_ff <= idx_ext) && (idx_ext < tbl_q_ff)) begin
               wt_in    = scan_wt;
               n_in     = scan_n;
               phase_in = PH_LEFT;
               base_in  = a_ff;
               wid_in   = scan_wt;
               col_in   = (scan_n == '0) ? scan_wt - SW'(1) : scan_n - SW'(1);
               left_in  = KW'(1);
               skip_in  = 1'b0;
               state_in = S_WALK;
            end else if (row_ff + TBL_AW'(1) == rows) begin
               state_in = S_FINISH;
            end else begin
               a_in      = tbl_q_ff;
               row_in    = row_ff + TBL_AW'(1);
               tbl_raddr = row_ff + TBL_AW'(2);
            end
         end
         S_WALK: begin
            if (left_ff == '0) begin
               unique case (phase_ff)
                  PH_LEFT: begin
                     phase_in = PH_RIGHT;
                     col_in   = ({1'b0, n_ff} + 22'd1 == {1'b0, wt_ff}) ? '0 : n_ff + SW'(1);
                     left_in  = KW'(1);
                  end
                  PH_RIGHT: begin
                     phase_in = PH_UP;
                     state_in = S_SIDE;
                  end
                  PH_UP: begin
                     phase_in = PH_DOWN;
                     state_in = S_SIDE;
                  end
                  PH_DOWN: begin
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end else if (full) begin
               state_in = S_FINISH;
            end else begin
               col_in  = col_next;
               left_in = left_ff - KW'(1);
               if (!(skip_ff && (col_ff == n_ff)) && cand_ok) begin
                  cand_in    = IW'(cand_id);
                  mask_raddr = MASK_AW'(IW'(cand_id) >> XW);
                  state_in   = S_JUDGE;
               end
            end
         end
         S_JUDGE: begin
            if (!mask_q_ff[cand_ff[XW-1:0]]) begin
               state_in = S_WALK;
            end else if (!pend_valid_ff || slot_free) begin
               // A result goes out only once the next one shows it is not the last.
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_id_in    = pend_ff;
                  out_found_in = 1'b1;
                  out_last_in  = 1'b0;
               end
               pend_in       = cand_ff;
               pend_valid_in = 1'b1;
               hit_cnt_in    = hit_cnt_ff + HIT_W'(1);
               state_in      = S_WALK;
            end
         end
         S_SIDE: begin
            if (polar) begin
               base_in  = a_ff;
               wid_in   = wt_ff;
               col_in   = '0;
               left_in  = KW'(wt_ff);
               skip_in  = 1'b1;
               state_in = S_WALK;
            end else begin
               o_in      = (phase_ff == PH_UP) ? row_ff + TBL_AW'(1) : row_ff - TBL_AW'(1);
               tbl_raddr = (phase_ff == PH_UP) ? row_ff + TBL_AW'(1) : row_ff - TBL_AW'(1);
               state_in  = S_ADJ1;
            end
         end
         S_ADJ1: begin
            so_in     = tbl_q_ff;
            tbl_raddr = o_ff + TBL_AW'(1);
            state_in  = S_ADJ2;
         end
         S_ADJ2: begin
            if (tbl_q_ff > so_ff) begin
               wo_in     = tbl_q_ff - so_ff;
               adj_hi_in = 1'b0;
               state_in  = S_MUL;
            end else begin
               left_in  = '0;
               state_in = S_WALK;
            end
         end
         S_MUL: begin
            // Column zero has a negative lower bound, found as a ceiling of wo / wt.
            prod_in   = mul_full;
            addend_in = (adj_hi_ff || (n_ff == '0)) ? wt_ff - SW'(1) : '0;
            state_in  = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (!div_busy) begin
               if (!adj_hi_ff) begin
                  lo_q_in   = div_quo;
                  adj_hi_in = 1'b1;
                  state_in  = S_MUL;
               end else begin
                  base_in = so_ff;
                  wid_in  = wo_ff;
                  skip_in = 1'b0;
                  if (n_ff == '0) begin
                     left_in = KW'(div_quo) + KW'(lo_q_ff) + KW'(1);
                     col_in  = (lo_q_ff == QW'(wo_ff)) ? '0 : wo_ff - SW'(lo_q_ff);
                  end else begin
                     left_in = KW'(div_quo) - KW'(lo_q_ff) + KW'(1);
                     col_in  = SW'(lo_q_ff);
                  end
                  state_in = S_WALK;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_id_in    = pend_valid_ff ? pend_ff : '0;
               out_found_in = pend_valid_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         phase_ff      <= PH_LEFT;
         clr_addr_ff   <= '0;
         pend_valid_ff <= 1'b0;
         hit_cnt_ff    <= '0;
         adj_hi_ff     <= 1'b0;
         left_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         clr_addr_ff   <= clr_addr_in;
         pend_valid_ff <= pend_valid_in;
         hit_cnt_ff    <= hit_cnt_in;
         adj_hi_ff     <= adj_hi_in;
         left_ff       <= left_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      row_ff       <= row_in;
      o_ff         <= o_in;
      a_ff         <= a_in;
      wt_ff        <= wt_in;
      n_ff         <= n_in;
      so_ff        <= so_in;
      wo_ff        <= wo_in;
      prod_ff      <= prod_in;
      addend_ff    <= addend_in;
      lo_q_ff      <= lo_q_in;
      base_ff      <= base_in;
      wid_ff       <= wid_in;
      col_ff       <= col_in;
      skip_ff      <= skip_in;
      cand_ff      <= cand_in;
      pend_ff      <= pend_in;
      out_id_ff    <= out_id_in;
      out_found_ff <= out_found_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_q_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wdata;
      end
      mask_q_ff <= mask_mem[mask_raddr];
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.neighbour_id = out_id_ff;
   assign rsp_if.found        = out_found_ff;
   assign rsp_if.last         = out_last_ff;

endmodule

>>> rtl/core/sphere_grid_neighbour_lister.sv
// Top level of the sphere grid neighbour lister.
// After reset the water mask is swept to land, one 16-node word per cycle,
// while no request item is taken. A row start load is then written from the
// idle state and a water load reads and writes back its mask word in S_WATER.
// A query scans the row start table one row per cycle from row 0, then passes
// through S_WALK and S_JUDGE for each neighbour candidate whose mask bit is
// probed; every upper or lower row that is neither polar nor empty needs two
// divisions on the shared bit-serial divider for its column range. The
// divider and the linear row scan set the query time. A two-entry queue lets
// request items be taken while the engine is busy.
module sphere_grid_neighbour_lister #(
   parameter int MAX_ROWS  = sgnl_pkg::DEF_MAX_ROWS,
   parameter int MAX_NODES = sgnl_pkg::DEF_MAX_NODES,
   parameter int MAX_OUT   = sgnl_pkg::DEF_MAX_OUT
) (
   input  logic                          clock,
   input  logic                          reset,
   sgnl_req_if.sink                      req_if,
   sgnl_rsp_if.source                    rsp_if,
   input  logic                          csr_we,
   input  logic [sgnl_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int ROW_W = $clog2(MAX_ROWS + 1);

   logic [sgnl_pkg::COUNT_W-1:0] row_count_ff;
   logic [ROW_W-1:0]             rows;
   sgnl_pkg::status_type         status;
   logic                         f_valid, f_ready;
   sgnl_pkg::cmd_type            f_cmd;
   logic                         q_valid, q_ready;
   sgnl_pkg::cmd_type            q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= sgnl_pkg::ROW_COUNT_RESET;
      end else if (csr_we) begin
         row_count_ff <= csr_wdata;
      end
   end

   // Rows in use, held to the range two to MAX_ROWS.
   always_comb begin
      priority if (row_count_ff < sgnl_pkg::ROW_COUNT_MIN) begin
         rows = ROW_W'(2);
      end else if (32'(row_count_ff) > 32'(MAX_ROWS)) begin
         rows = ROW_W'(MAX_ROWS);
      end else begin
         rows = ROW_W'(row_count_ff);
      end
   end

   sgnl_front #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .status    (status),
      .cmd_valid (f_valid),
      .cmd       (f_cmd),
      .cmd_ready (f_ready)
   );

   sgnl_queue #(
      .DEPTH (sgnl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_cmd    (f_cmd),
      .in_ready  (f_ready),
      .out_valid (q_valid),
      .out_cmd   (q_cmd),
      .out_ready (q_ready)
   );

   sgnl_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_NODES (MAX_NODES),
      .MAX_OUT   (MAX_OUT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_ready (q_ready),
      .rows      (rows),
      .status    (status),
      .rsp_if    (rsp_if)
   );

endmodule

>>> rtl/core/sgnl_checker.sv
// Port-level checks on the result stream of the neighbour lister, bound to the top level.
module sgnl_checker #(
   parameter int MAX_OUT = sgnl_pkg::DEF_MAX_OUT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sgnl_pkg::ID_W-1:0]   rsp_id,
   input logic                        rsp_found,
   input logic                        rsp_last
);

   localparam int RUN_W = $clog2(MAX_OUT + 1);

   logic [RUN_W-1:0] run_ff;

   // Results delivered so far in the current query.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         run_ff <= rsp_last ? '0 : run_ff + RUN_W'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id) && $stable(rsp_found)
                                  && $stable(rsp_last))
      else $error("result item changed while stalled");

   a_notfound_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("not-found result is not the last of its query");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_id == '0)
      else $error("not-found result carries a nonzero id");

   a_run_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> run_ff < RUN_W'(MAX_OUT - 1))
      else $error("query delivered more results than allowed");

endmodule

bind sphere_grid_neighbour_lister sgnl_checker #(
   .MAX_OUT (MAX_OUT)
) u_sgnl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_id    (rsp_if.neighbour_id),
   .rsp_found (rsp_if.found),
   .rsp_last  (rsp_if.last)
);
